// ===== rtl/flh_pkg.sv =====
`default_nettype none
package flh_pkg;

	localparam int NUM_FAULTS   = 64;
	localparam int SORTED_DEPTH = 16;
	localparam int EVENT_DEPTH  = 16;

	localparam int ACT_W   = 3;
	localparam int ID_W    = 6;
	localparam int POS_W   = 4;
	localparam int BITS_W  = 64;
	localparam int COUNT_W = 7;

	localparam logic [BITS_W-1:0] VALID_MASK = (NUM_FAULTS >= BITS_W) ? {BITS_W{1'b1}} :
		((64'd1 << NUM_FAULTS) - 64'd1);

	localparam int MAX_DEPTH = (SORTED_DEPTH > EVENT_DEPTH) ? SORTED_DEPTH : EVENT_DEPTH;
	localparam int S_AW      = (SORTED_DEPTH > 1) ? $clog2(SORTED_DEPTH) : 1;
	localparam int E_AW      = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int SWEEP_W   = $clog2(MAX_DEPTH + 1);

	localparam logic [ACT_W-1:0] ACT_SET         = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RESET_LATCH = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FLUSH       = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ        = 3'd4;

	typedef struct packed {
		logic            start;
		logic            flush;
		logic            rd;
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] pos;
	} hist_ctrl_t;

	typedef struct packed {
		logic            busy;
		logic            any_nz;
		logic [ID_W-1:0] sorted_entry;
		logic [ID_W-1:0] event_entry;
	} hist_stat_t;

	typedef struct packed {
		logic [COUNT_W-1:0] active;
		logic [COUNT_W-1:0] latched;
		logic [COUNT_W-1:0] warn;
	} count_t;

endpackage
`default_nettype wire

// ===== rtl/flh_if.sv =====
`default_nettype none
interface flh_in_if;
	import flh_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [ID_W-1:0]   fault_index;
	logic [POS_W-1:0]  position;
	modport source(output valid, action, fault_index, position, input ready);
	modport sink(input valid, action, fault_index, position, output ready);
endinterface

interface flh_out_if;
	import flh_pkg::*;
	logic               valid;
	logic               ready;
	logic               faulted;
	logic               warned;
	logic               changed;
	logic [COUNT_W-1:0] active_fault_count;
	logic [COUNT_W-1:0] latched_fault_count;
	logic [COUNT_W-1:0] warning_count;
	logic               latched_bit;
	logic [ID_W-1:0]    sorted_entry;
	logic [ID_W-1:0]    event_entry;
	modport source(output valid, faulted, warned, changed, active_fault_count,
		latched_fault_count, warning_count, latched_bit, sorted_entry, event_entry,
		input ready);
	modport sink(input valid, faulted, warned, changed, active_fault_count,
		latched_fault_count, warning_count, latched_bit, sorted_entry, event_entry,
		output ready);
endinterface

interface flh_cfg_if;
	import flh_pkg::*;
	logic              valid;
	logic              ready;
	logic [BITS_W-1:0] self_clear_mask;
	modport source(output valid, self_clear_mask, input ready);
	modport sink(input valid, self_clear_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/flh_ram.sv =====
`default_nettype none
module flh_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 6,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/flh_hist.sv =====
`default_nettype none
module flh_hist (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire flh_pkg::hist_ctrl_t ctrl,
	output      flh_pkg::hist_stat_t stat
);
	import flh_pkg::*;

	logic                    run_q;
	logic                    s_run_q;
	logic [SWEEP_W-1:0]      rcnt_q;
	logic [SWEEP_W-1:0]      wcnt_s1;
	logic                    rv_s1;
	logic [ID_W-1:0]         id_q;
	logic [ID_W-1:0]         carry_s_q;
	logic [ID_W-1:0]         carry_e_q;
	logic [SORTED_DEPTH-1:0] nz_s_q;
	logic [EVENT_DEPTH-1:0]  nz_e_q;
	logic                    nzr_s_q;
	logic                    nzr_e_q;
	logic                    pos_s_ok_q;
	logic                    pos_e_ok_q;

	logic                    issue;
	logic                    s_re;
	logic                    e_re;
	logic [S_AW-1:0]         s_raddr;
	logic [E_AW-1:0]         e_raddr;
	logic                    s_we;
	logic                    e_we;
	logic [S_AW-1:0]         s_waddr;
	logic [E_AW-1:0]         e_waddr;
	logic [ID_W-1:0]         s_rdata;
	logic [ID_W-1:0]         e_rdata;
	logic [ID_W-1:0]         old_s;
	logic [ID_W-1:0]         old_e;
	logic                    s_stop;
	logic                    last;

	flh_ram #(.DEPTH(SORTED_DEPTH), .WIDTH(ID_W), .AW(S_AW)) u_sorted_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (carry_s_q),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	flh_ram #(.DEPTH(EVENT_DEPTH), .WIDTH(ID_W), .AW(E_AW)) u_event_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (carry_e_q),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	always_comb begin
		issue   = run_q && (rcnt_q < SWEEP_W'(MAX_DEPTH));
		s_re    = run_q ? (issue && (rcnt_q < SWEEP_W'(SORTED_DEPTH))) : ctrl.rd;
		e_re    = run_q ? (issue && (rcnt_q < SWEEP_W'(EVENT_DEPTH))) : ctrl.rd;
		s_raddr = run_q ? S_AW'(rcnt_q) : S_AW'(ctrl.pos);
		e_raddr = run_q ? E_AW'(rcnt_q) : E_AW'(ctrl.pos);
		old_s   = nzr_s_q ? s_rdata : '0;
		old_e   = nzr_e_q ? e_rdata : '0;
		s_we    = rv_s1 && s_run_q && (wcnt_s1 < SWEEP_W'(SORTED_DEPTH));
		e_we    = rv_s1 && (wcnt_s1 < SWEEP_W'(EVENT_DEPTH));
		s_waddr = S_AW'(wcnt_s1);
		e_waddr = E_AW'(wcnt_s1);
		s_stop  = (wcnt_s1 == SWEEP_W'(SORTED_DEPTH - 1)) || (old_s == id_q);
		last    = (wcnt_s1 == SWEEP_W'(MAX_DEPTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			s_run_q <= 1'b0;
			rcnt_q  <= '0;
			rv_s1   <= 1'b0;
		end else if (ctrl.start) begin
			run_q   <= 1'b1;
			s_run_q <= 1'b1;
			rcnt_q  <= '0;
			rv_s1   <= 1'b0;
		end else if (run_q) begin
			if (issue) begin
				rcnt_q <= rcnt_q + SWEEP_W'(1);
			end
			rv_s1 <= issue;
			if (rv_s1 && s_stop) begin
				s_run_q <= 1'b0;
			end
			if (rv_s1 && last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			id_q      <= ctrl.id;
			carry_s_q <= ctrl.id;
			carry_e_q <= ctrl.id;
		end else if (rv_s1) begin
			carry_s_q <= old_s;
			carry_e_q <= old_e;
		end
		if (run_q) begin
			wcnt_s1 <= rcnt_q;
		end
		if (s_re) begin
			nzr_s_q <= nz_s_q[s_raddr];
		end
		if (e_re) begin
			nzr_e_q <= nz_e_q[e_raddr];
		end
		if (ctrl.rd) begin
			pos_s_ok_q <= int'(ctrl.pos) < SORTED_DEPTH;
			pos_e_ok_q <= int'(ctrl.pos) < EVENT_DEPTH;
		end
	end

	// a clear entry reads as zero, so flush only drops these bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_s_q <= '0;
			nz_e_q <= '0;
		end else if (ctrl.flush) begin
			nz_s_q <= '0;
			nz_e_q <= '0;
		end else begin
			if (s_we) begin
				nz_s_q[s_waddr] <= (carry_s_q != '0);
			end
			if (e_we) begin
				nz_e_q[e_waddr] <= (carry_e_q != '0);
			end
		end
	end

	always_comb begin
		stat.busy         = run_q;
		stat.any_nz       = (nz_s_q != '0) || (nz_e_q != '0);
		stat.sorted_entry = (pos_s_ok_q && nzr_s_q) ? s_rdata : '0;
		stat.event_entry  = (pos_e_ok_q && nzr_e_q) ? e_rdata : '0;
	end
endmodule
`default_nettype wire

// ===== rtl/flh_count.sv =====
`default_nettype none
module flh_count (
	input  wire logic                         clk,
	input  wire logic [flh_pkg::BITS_W-1:0]   active,
	input  wire logic [flh_pkg::BITS_W-1:0]   latched,
	input  wire logic [flh_pkg::BITS_W-1:0]   mask,
	input  wire logic                         en1,
	input  wire logic                         en2,
	output      flh_pkg::count_t              cnt
);
	import flh_pkg::*;

	localparam int GRP   = 8;
	localparam int NGRP  = BITS_W / GRP;
	localparam int GRP_W = $clog2(GRP + 1);

	logic [BITS_W-1:0] act_lat;
	logic [BITS_W-1:0] lat_lat;
	logic [BITS_W-1:0] act_warn;
	logic [GRP_W-1:0]  ga_s1 [NGRP];
	logic [GRP_W-1:0]  gl_s1 [NGRP];
	logic [GRP_W-1:0]  gw_s1 [NGRP];
	logic [GRP_W-1:0]  ga_d  [NGRP];
	logic [GRP_W-1:0]  gl_d  [NGRP];
	logic [GRP_W-1:0]  gw_d  [NGRP];
	count_t            sum_d;

	always_comb begin
		act_lat  = active & ~mask & VALID_MASK;
		lat_lat  = latched & ~mask & VALID_MASK;
		act_warn = active & mask & VALID_MASK;
		for (int g = 0; g < NGRP; g++) begin
			ga_d[g] = '0;
			gl_d[g] = '0;
			gw_d[g] = '0;
			for (int b = 0; b < GRP; b++) begin
				ga_d[g] = ga_d[g] + GRP_W'(act_lat[g*GRP+b]);
				gl_d[g] = gl_d[g] + GRP_W'(lat_lat[g*GRP+b]);
				gw_d[g] = gw_d[g] + GRP_W'(act_warn[g*GRP+b]);
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_d.active  = sum_d.active + COUNT_W'(ga_s1[g]);
			sum_d.latched = sum_d.latched + COUNT_W'(gl_s1[g]);
			sum_d.warn    = sum_d.warn + COUNT_W'(gw_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ga_s1 <= ga_d;
			gl_s1 <= gl_d;
			gw_s1 <= gw_d;
		end
		if (en2) begin
			cnt <= sum_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fault_latch_history_unit.sv =====
`default_nettype none
// Fault latch unit with a move-to-front history and an event history. Each beat on item
// sets, clears or tests one fault, resets the latches, flushes both histories or reads
// back a history slot, and answers exactly one beat on result with the flags and counts
// as they stand after it. A set of an inactive fault sweeps both history memories, one
// slot per cycle through their single read port, before the two-stage population count
// and the history read; every other action goes straight from execution to the count
// and the read. One item is in work at a time; the next is taken in the cycle after a
// result is loaded into the output register, even while that result waits. The user
// must write the self-clear mask on cfg only while no item is in work; the block does
// not enforce this. The mask needs no other setup.
module fault_latch_history_unit (
	input wire logic clk,
	input wire logic arst_n,
	flh_in_if.sink   item,
	flh_out_if.source result,
	flh_cfg_if.sink  cfg
);
	import flh_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXEC   = 6'b000010,
		ST_SWEEP  = 6'b000100,
		ST_CNT1   = 6'b001000,
		ST_CNT2   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [BITS_W-1:0]  mask_q;
	logic [BITS_W-1:0]  active_q;
	logic [BITS_W-1:0]  latched_q;
	logic [ACT_W-1:0]   act_q;
	logic [ID_W-1:0]    idx_q;
	logic [POS_W-1:0]   pos_q;
	logic               changed_q;
	logic               out_valid_q;

	logic               faulted_q;
	logic               warned_q;
	logic               out_changed_q;
	logic [COUNT_W-1:0] afc_q;
	logic [COUNT_W-1:0] lfc_q;
	logic [COUNT_W-1:0] wc_q;
	logic               latched_bit_q;
	logic [ID_W-1:0]    sorted_q;
	logic [ID_W-1:0]    event_q;

	logic               in_range;
	logic               do_set;
	logic               do_clear;
	logic               do_rlatch;
	logic               exec_changed;
	logic               load_out;
	hist_ctrl_t         hctrl;
	hist_stat_t         hstat;
	count_t             cnt;

	flh_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hctrl),
		.stat   (hstat)
	);

	flh_count u_count (
		.clk     (clk),
		.active  (active_q),
		.latched (latched_q),
		.mask    (mask_q),
		.en1     (state_q == ST_CNT1),
		.en2     (state_q == ST_CNT2),
		.cnt     (cnt)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	always_comb begin
		in_range     = {1'b0, idx_q} < (ID_W + 1)'(NUM_FAULTS);
		do_set       = 1'b0;
		do_clear     = 1'b0;
		do_rlatch    = 1'b0;
		exec_changed = 1'b0;
		hctrl        = '0;
		hctrl.id     = idx_q;
		hctrl.pos    = pos_q;
		hctrl.rd     = (state_q == ST_CNT1);
		if (state_q == ST_EXEC) begin
			unique case (act_q)
				ACT_SET: begin
					do_set       = in_range && !active_q[idx_q];
					exec_changed = do_set;
					hctrl.start  = do_set;
				end
				ACT_CLEAR: begin
					do_clear     = in_range && active_q[idx_q];
					exec_changed = do_clear;
				end
				ACT_RESET_LATCH: begin
					do_rlatch    = (latched_q != active_q);
					exec_changed = do_rlatch;
				end
				ACT_FLUSH: begin
					hctrl.flush  = 1'b1;
					exec_changed = hstat.any_nz;
				end
				ACT_READ: begin
					exec_changed = 1'b0;
				end
				default: begin
					exec_changed = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		load_out = (state_q == ST_FINISH) && (!out_valid_q || result.ready);
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = hctrl.start ? ST_SWEEP : ST_CNT1;
			end
			ST_SWEEP: begin
				if (!hstat.busy) begin
					state_d = ST_CNT1;
				end
			end
			ST_CNT1: begin
				state_d = ST_CNT2;
			end
			ST_CNT2: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			active_q    <= '0;
			latched_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				mask_q <= cfg.self_clear_mask;
			end
			if (do_set) begin
				active_q[idx_q]  <= 1'b1;
				latched_q[idx_q] <= 1'b1;
			end
			if (do_clear) begin
				active_q[idx_q] <= 1'b0;
				if (mask_q[idx_q]) begin
					latched_q[idx_q] <= 1'b0;
				end
			end
			if (do_rlatch) begin
				latched_q <= active_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			act_q <= item.action;
			idx_q <= item.fault_index;
			pos_q <= item.position;
		end
		if (state_q == ST_EXEC) begin
			changed_q <= exec_changed;
		end
		if (load_out) begin
			faulted_q     <= (cnt.latched != '0);
			warned_q      <= (cnt.warn != '0);
			out_changed_q <= changed_q;
			afc_q         <= cnt.active;
			lfc_q         <= cnt.latched;
			wc_q          <= cnt.warn;
			latched_bit_q <= in_range && latched_q[idx_q];
			sorted_q      <= hstat.sorted_entry;
			event_q       <= hstat.event_entry;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.faulted             = faulted_q;
	assign result.warned              = warned_q;
	assign result.changed             = out_changed_q;
	assign result.active_fault_count  = afc_q;
	assign result.latched_fault_count = lfc_q;
	assign result.warning_count       = wc_q;
	assign result.latched_bit         = latched_bit_q;
	assign result.sorted_entry        = sorted_q;
	assign result.event_entry         = event_q;
endmodule
`default_nettype wire

// ===== dv/fault_status_checker.sv =====
`timescale 1ns / 1ps
module fault_status_checker
	import flh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	flh_in_if    item,
	flh_out_if   result,
	flh_cfg_if   cfg,
	output int   fail_count,
	output int   pending_results
);

	typedef struct packed {
		logic               faulted;
		logic               warned;
		logic               changed;
		logic [COUNT_W-1:0] active_fault_count;
		logic [COUNT_W-1:0] latched_fault_count;
		logic [COUNT_W-1:0] warning_count;
		logic               latched_bit;
		logic [ID_W-1:0]    sorted_entry;
		logic [ID_W-1:0]    event_entry;
	} fault_status_t;

	logic [BITS_W-1:0] clear_mask;
	logic [BITS_W-1:0] active_bits;
	logic [BITS_W-1:0] latched_bits;
	logic [ID_W-1:0]   sorted_hist [SORTED_DEPTH];
	logic [ID_W-1:0]   event_hist [EVENT_DEPTH];
	fault_status_t     expected_status [$];
	fault_status_t     want;

	function automatic fault_status_t apply_action(input logic [ACT_W-1:0] act,
		input logic [ID_W-1:0] idx, input logic [POS_W-1:0] pos);
		fault_status_t     r;
		logic [BITS_W-1:0] warn_m;
		logic [BITS_W-1:0] latch_m;
		logic [BITS_W-1:0] one_hot;
		logic              in_range;
		logic              touched;
		int                k;
		warn_m   = clear_mask & VALID_MASK;
		latch_m  = ~clear_mask & VALID_MASK;
		in_range = (int'(idx) < NUM_FAULTS);
		one_hot  = {{(BITS_W-1){1'b0}}, 1'b1} << idx;
		touched  = 1'b0;
		case (act)
			ACT_SET: begin
				if (in_range && (active_bits & one_hot) == '0) begin
					active_bits  = active_bits | one_hot;
					latched_bits = latched_bits | one_hot;
					// move to front, no duplicates
					k = 0;
					while (k < SORTED_DEPTH - 1 && sorted_hist[k] != idx)
						k++;
					while (k > 0) begin
						sorted_hist[k] = sorted_hist[k-1];
						k--;
					end
					sorted_hist[0] = idx;
					for (k = EVENT_DEPTH - 1; k > 0; k--)
						event_hist[k] = event_hist[k-1];
					event_hist[0] = idx;
					touched = 1'b1;
				end
			end
			ACT_CLEAR: begin
				if (in_range && (active_bits & one_hot) != '0) begin
					active_bits = active_bits & ~one_hot;
					if ((warn_m & one_hot) != '0)
						latched_bits = latched_bits & ~one_hot;
					touched = 1'b1;
				end
			end
			ACT_RESET_LATCH: begin
				if (latched_bits != active_bits) begin
					latched_bits = active_bits;
					touched      = 1'b1;
				end
			end
			ACT_FLUSH: begin
				for (k = 0; k < SORTED_DEPTH; k++) begin
					if (sorted_hist[k] != '0)
						touched = 1'b1;
					sorted_hist[k] = '0;
				end
				for (k = 0; k < EVENT_DEPTH; k++) begin
					if (event_hist[k] != '0)
						touched = 1'b1;
					event_hist[k] = '0;
				end
			end
			default: ;
		endcase
		r.active_fault_count  = COUNT_W'($countones(active_bits & latch_m));
		r.latched_fault_count = COUNT_W'($countones(latched_bits & latch_m));
		r.warning_count       = COUNT_W'($countones(active_bits & warn_m));
		r.faulted             = (r.latched_fault_count != '0);
		r.warned              = (r.warning_count != '0);
		r.changed             = touched;
		r.latched_bit         = in_range && ((latched_bits & one_hot) != '0);
		r.sorted_entry        = (int'(pos) < SORTED_DEPTH) ? sorted_hist[pos] : '0;
		r.event_entry         = (int'(pos) < EVENT_DEPTH) ? event_hist[pos] : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
		input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_mask   = '0;
			active_bits  = '0;
			latched_bits = '0;
			for (int k = 0; k < SORTED_DEPTH; k++)
				sorted_hist[k] = '0;
			for (int k = 0; k < EVENT_DEPTH; k++)
				event_hist[k] = '0;
			expected_status.delete();
			pending_results = 0;
			fail_count      = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				clear_mask = cfg.self_clear_mask;
			if (result.valid && result.ready) begin
				if (expected_status.size() == 0) begin
					$error("result beat with no status expected");
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					check_field("faulted", want.faulted, result.faulted);
					check_field("warned", want.warned, result.warned);
					check_field("changed", want.changed, result.changed);
					check_field("active_fault_count", want.active_fault_count,
						result.active_fault_count);
					check_field("latched_fault_count", want.latched_fault_count,
						result.latched_fault_count);
					check_field("warning_count", want.warning_count, result.warning_count);
					check_field("latched_bit", want.latched_bit, result.latched_bit);
					check_field("sorted_entry", want.sorted_entry, result.sorted_entry);
					check_field("event_entry", want.event_entry, result.event_entry);
				end
			end
			if (item.valid && item.ready)
				expected_status.push_back(apply_action(item.action, item.fault_index,
					item.position));
			pending_results = expected_status.size();
		end
	end

endmodule

// ===== dv/fault_latch_history_unit_tb.sv =====
`timescale 1ns / 1ps
module fault_latch_history_unit_tb;
	import flh_pkg::*;

	localparam logic [ACT_W-1:0] ACT_NOOP_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NOOP_MID   = 3'd6;
	localparam logic [ACT_W-1:0] ACT_NOOP_LAST  = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 270;
	localparam int ID_POOL        = 23;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending_results;
	int   tx_rate;
	int   rx_rate;
	bit   hold_req;

	flh_in_if  item_ch ();
	flh_out_if result_ch ();
	flh_cfg_if cfg_ch ();

	fault_latch_history_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	fault_status_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always #1 clk = ~clk;

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] idx,
		input logic [POS_W-1:0] pos);
		item_ch.valid       <= 1'b1;
		item_ch.action      <= act;
		item_ch.fault_index <= idx;
		item_ch.position    <= pos;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
		if ($urandom_range(0, 99) < tx_rate) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	task automatic write_mask(input logic [BITS_W-1:0] mask);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.self_clear_mask <= mask;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly a small pool of ids so the histories fill and entries move to front
	task automatic send_random_item(output bit counted);
		logic [ACT_W-1:0] act;
		logic [ID_W-1:0]  idx;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 36)
			act = ACT_SET;
		else if (pick < 68)
			act = ACT_CLEAR;
		else if (pick < 76)
			act = ACT_RESET_LATCH;
		else if (pick < 80)
			act = ACT_FLUSH;
		else if (pick < 97)
			act = ACT_READ;
		else
			act = ACT_W'($urandom_range(ACT_NOOP_FIRST, ACT_NOOP_LAST));
		if ($urandom_range(0, 99) < 65)
			idx = ID_W'($urandom_range(0, ID_POOL));
		else
			idx = ID_W'($urandom());
		send_item(act, idx, POS_W'($urandom()));
		counted = (act <= ACT_READ);
	endtask

	initial begin
		logic [BITS_W-1:0] mask;
		int                sent;
		bit                counted;
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.action         = ACT_READ;
		item_ch.fault_index    = '0;
		item_ch.position       = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.self_clear_mask = '0;
		tx_rate                = 20;
		rx_rate                = 20;
		hold_req               = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state, all faults latching
		send_item(ACT_READ, 6'd0, 4'd0);
		send_item(ACT_READ, 6'd63, 4'd15);
		send_item(ACT_CLEAR, 6'd5, 4'd0);
		send_item(ACT_SET, 6'd0, 4'd0);
		send_item(ACT_SET, 6'd63, 4'd0);
		send_item(ACT_SET, 6'd63, 4'd1);
		send_item(ACT_RESET_LATCH, 6'd63, 4'd0);
		send_item(ACT_CLEAR, 6'd63, 4'd1);
		send_item(ACT_READ, 6'd63, 4'd1);
		send_item(ACT_RESET_LATCH, 6'd63, 4'd15);
		send_item(ACT_FLUSH, 6'd0, 4'd0);
		send_item(ACT_FLUSH, 6'd0, 4'd1);
		send_item(ACT_NOOP_FIRST, 6'd0, 4'd0);
		send_item(ACT_NOOP_MID, 6'd63, 4'd15);
		send_item(ACT_NOOP_LAST, 6'd0, 4'd0);
		drain();
		write_mask('1);
		send_item(ACT_SET, 6'd10, 4'd0);
		send_item(ACT_SET, 6'd20, 4'd1);
		send_item(ACT_CLEAR, 6'd10, 4'd0);
		send_item(ACT_READ, 6'd20, 4'd0);
		drain();
		write_mask(64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ACT_SET, 6'd7, 4'd0);
		send_item(ACT_CLEAR, 6'd20, 4'd2);
		send_item(ACT_RESET_LATCH, 6'd20, 4'd0);
		send_item(ACT_SET, 6'd10, 4'd0);
		send_item(ACT_READ, 6'd0, 4'd3);

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: mask = {$urandom(), $urandom()};
				1: mask = '0;
				2: mask = '1;
				3: mask = {$urandom(), $urandom()} & {$urandom(), $urandom()};
				default: mask = {$urandom(), $urandom()};
			endcase
			write_mask(mask);
			case (ph)
				0: begin tx_rate = 20; rx_rate = 20; end
				1: begin tx_rate = 0;  rx_rate = 0;  end
				2: begin tx_rate = 10; rx_rate = 30; hold_req = 1'b1; end
				3: begin tx_rate = 40; rx_rate = 10; end
				default: begin tx_rate = 0; rx_rate = 0; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				send_random_item(counted);
				if (counted)
					sent++;
				if (ph == 3 && sent == PHASE_ITEMS / 2 && counted)
					drain();
			end
		end

		drain();
		repeat (MAX_DEPTH + 16) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		bit hold_taken;
		hold_taken      = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken      = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if ($urandom_range(0, 99) < rx_rate) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/flh_pkg.sv
rtl/flh_if.sv
rtl/flh_ram.sv
rtl/flh_hist.sv
rtl/flh_count.sv
rtl/fault_latch_history_unit.sv
dv/fault_status_checker.sv
dv/fault_latch_history_unit_tb.sv
